// ===== design/uer_pkg.sv =====
// Package for the ultrasonic echo ranging controller: item and configuration
// types, phase and status codes, register indexes and reset values.
// No dependencies; used by uer_cfg_regs, uer_core and the top level.
package uer_pkg;

  // Default width of the phase tick counter
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_W      = 16;  // width of the 16-bit time registers
  localparam int unsigned TRIG_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LOW   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ECHO     = CFG_IDX_W'(3);

  localparam logic [CFG_W-1:0]  SETTLE_LOW_RST   = 16'd30000;
  localparam logic [TRIG_W-1:0] TRIGGER_HIGH_RST = 10'd20;
  localparam logic [CFG_W-1:0]  ECHO_TIMEOUT_RST = 16'd30000;
  localparam logic [CFG_W-1:0]  MAX_ECHO_RST     = 16'd25999;

  // Distance scale: 0.1716 mm per us in Q16
  localparam int unsigned SPEED_W   = 14;
  localparam logic [SPEED_W-1:0] SPEED_Q16 = 14'd11246;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = CFG_W + SPEED_W;
  localparam int unsigned DIST_W    = 15;

  // Measurement phases
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SETTLE = 3'd1;
  localparam logic [2:0] PH_TRIG   = 3'd2;
  localparam logic [2:0] PH_WAIT   = 3'd3;
  localparam logic [2:0] PH_ECHO   = 3'd4;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    status_e           status;
    logic [DIST_W-1:0] distance_mm;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [CFG_W-1:0]  settle_low_us;
    logic [TRIG_W-1:0] trigger_high_us;
    logic [CFG_W-1:0]  echo_timeout_us;
    logic [CFG_W-1:0]  max_echo_us;
  } cfg_t;

endpackage

// ===== design/uer_chan_if.sv =====
// Valid/ready channel interface carrying one payload item per handshake.
// Payload type is a parameter; used with the item types of uer_pkg.
interface uer_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/uer_cfg_regs.sv =====
// Configuration register file of the echo ranging controller.
// Depends on uer_pkg for indexes, widths and reset values.
module uer_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  uer_pkg::cfg_wr_t wr_i,
  output uer_pkg::cfg_t   cfg_o
);
  import uer_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_i.index)
        REG_SETTLE_LOW:   cfg_d.settle_low_us   = wr_i.data[CFG_W-1:0];
        REG_TRIGGER_HIGH: cfg_d.trigger_high_us = wr_i.data[TRIG_W-1:0];
        REG_ECHO_TIMEOUT: cfg_d.echo_timeout_us = wr_i.data[CFG_W-1:0];
        REG_MAX_ECHO:     cfg_d.max_echo_us     = wr_i.data[CFG_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_low_us   <= SETTLE_LOW_RST;
      cfg_q.trigger_high_us <= TRIGGER_HIGH_RST;
      cfg_q.echo_timeout_us <= ECHO_TIMEOUT_RST;
      cfg_q.max_echo_us     <= MAX_ECHO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

// ===== design/uer_core.sv =====
// Measurement sequencer: phase, tick counter and echo edge detect, plus the
// result for each tick item. Depends on uer_pkg.
module uer_core #(
  parameter int unsigned COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  uer_pkg::in_item_t  item_i,
  input  uer_pkg::cfg_t      cfg_i,
  output uer_pkg::out_item_t res_o
);
  import uer_pkg::*;

  localparam int unsigned CmpW = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;

  logic [2:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  echo_prev_q;

  logic [CFG_W-1:0]      limit;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  cnt_sat;
  logic                  over;
  logic [CmpW-1:0]       cnt_wide;
  logic                  too_long;
  logic [PROD_W-1:0]     prod;
  logic                  done;
  status_e               status;
  logic [DIST_W-1:0]     dist_mm;

  // Phase length for the counting phases
  always_comb begin
    case (phase_q)
      PH_SETTLE: limit = cfg_i.settle_low_us;
      PH_TRIG:   limit = CFG_W'(cfg_i.trigger_high_us);
      default:   limit = cfg_i.echo_timeout_us;
    endcase
  end

  // Saturating count step; a full counter ends the phase
  assign cnt_sat = &cnt_q;
  assign cnt_inc = cnt_q + COUNT_BITS'(1);
  assign over    = cnt_sat || (CmpW'(cnt_inc) >= CmpW'(limit)) || (&cnt_inc);

  // Echo width check and distance scaling (only used when within max_echo_us,
  // so the low 16 bits hold the whole count)
  assign cnt_wide = CmpW'(cnt_q);
  assign too_long = cnt_wide > CmpW'(cfg_i.max_echo_us);
  assign prod     = PROD_W'(cnt_wide[CFG_W-1:0]) * PROD_W'(SPEED_Q16);

  // Next phase and result
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done    = 1'b0;
    status  = ST_VALID;
    dist_mm = '0;
    case (phase_q)
      PH_IDLE: begin
        if (item_i.start_req) begin
          phase_d = PH_SETTLE;
          cnt_d   = '0;
        end
      end
      PH_SETTLE: begin
        if (over) begin
          phase_d = PH_TRIG;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_TRIG: begin
        if (over) begin
          phase_d = PH_WAIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_WAIT: begin
        if (item_i.echo_level && !echo_prev_q) begin
          phase_d = PH_ECHO;
          cnt_d   = '0;
        end
      end
      PH_ECHO: begin
        if (!item_i.echo_level) begin
          done    = 1'b1;
          phase_d = PH_IDLE;
          cnt_d   = '0;
          if (too_long) begin
            status = ST_RANGE;
          end else begin
            dist_mm = DIST_W'(prod[PROD_W-1:FRAC_BITS]);
          end
        end else if (over) begin
          done    = 1'b1;
          status  = ST_TIMEOUT;
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      echo_prev_q <= 1'b0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      echo_prev_q <= item_i.echo_level;
    end
  end

  assign res_o.trigger_level = (phase_d == PH_TRIG);
  assign res_o.busy_res      = (phase_d != PH_IDLE);
  assign res_o.done_res      = done;
  assign res_o.status        = status;
  assign res_o.distance_mm   = dist_mm;
endmodule

// ===== design/ultrasonic_echo_ranging_top.sv =====
// Ultrasonic echo ranging controller. Each input item is one microsecond
// tick carrying start_req and the sampled echo level; each accepted item
// gives exactly one result item with the trigger level, busy/done flags,
// status and distance in mm. The block takes one item per clock cycle
// while the output is not stalled: an item is captured in an input
// register, then the sequencer updates its phase and counter and writes
// the result register, and the sequencer's single state update per tick
// sets the rate. Configuration writes are taken at any time but must
// only be made while no items are in flight. Depends on uer_pkg,
// uer_chan_if, uer_cfg_regs and uer_core.
module ultrasonic_echo_ranging_top #(
  parameter int unsigned COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  uer_chan_if.sink   in_i,
  uer_chan_if.source out_o,
  uer_chan_if.sink   cfg_i
);
  import uer_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;
  logic      in_ready;

  // Configuration registers, always ready
  assign cfg_i.ready = 1'b1;

  uer_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .cfg_o   (cfg)
  );

  // Pipeline control: the result register moves when empty or taken
  assign advance  = out_o.ready || !out_valid_q;
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  uer_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance && in_valid_q),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Input side only stalls when both stages hold items
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free pipeline stage");

  // A finished measurement leaves the block idle and the trigger low
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done_res) |-> (!out_q.busy_res && !out_q.trigger_level))
    else $error("done result while still busy");

  // Status and distance only carry meaning on a done result
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ((out_q.status != ST_VALID) || (out_q.distance_mm != '0)))
      |-> out_q.done_res)
    else $error("status or distance without done");

  // A distance is only reported with a valid status
  a_dist_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.distance_mm != '0)) |-> (out_q.status == ST_VALID))
    else $error("distance reported with error status");
endmodule
